/* sv/plrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrf_pkg
// Types and constants of the set/clear/toggle register file with PLL mirrors.
// ----------------------------------------------------------------------------
package plrf_pkg;

    localparam int DEF_STORE_WORDS = 16384;

    localparam int ADDR_W = 14;
    localparam int DATA_W = 32;

    // PLL window in word indices
    localparam logic [ADDR_W-1:0] WIN_FIRST_WORD = 14'h400;
    localparam logic [ADDR_W-1:0] WIN_END_WORD   = 14'h680;
    localparam logic [7:0]        WIN_FIRST_BLK  = 8'd16;

    localparam int PLL_BLOCKS = 10;
    localparam int BLK_W      = 4;
    localparam int DFS_COUNT  = 4;

    // word offsets inside one PLL block
    localparam logic [5:0] CTRL_REG        = 6'h00;
    localparam logic [5:0] DFS_FIRST_REG   = 6'h1c;
    localparam logic [5:0] LOCK_STATUS_REG = 6'h3c;
    localparam logic [5:0] DFS_STATUS_REG  = 6'h3d;

    localparam int POWERUP_BIT    = 0;
    localparam int DFS_ENABLE_BIT = 31;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [1:0] GRP_ASSIGN = 2'd0;
    localparam logic [1:0] GRP_SET    = 2'd1;
    localparam logic [1:0] GRP_CLR    = 2'd2;
    localparam logic [1:0] GRP_TOG    = 2'd3;

    typedef enum logic [3:0] {
        OP_READ_MEM,
        OP_READ_ZERO,
        OP_READ_LOCK,
        OP_READ_DFS,
        OP_WRITE,
        OP_SET,
        OP_CLR,
        OP_TOG,
        OP_NOP
    } t_op;

endpackage
`default_nettype wire

/* sv/plrf_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plrf_store
// Word store, one read and one write port, registered read data. Runs a
// clearing pass over every word after reset and reports busy meanwhile.
// ----------------------------------------------------------------------------
module plrf_store #(
    parameter int STORE_WORDS = plrf_pkg::DEF_STORE_WORDS,
    localparam int AW = $clog2(STORE_WORDS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    output logic                             o_busy,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic [plrf_pkg::DATA_W-1:0]      o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [plrf_pkg::DATA_W-1:0] i_wr_data
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

    logic [plrf_pkg::DATA_W-1:0] r_mem [STORE_WORDS];
    logic [plrf_pkg::DATA_W-1:0] r_rd_data;
    logic                        r_clr_busy;
    logic                        n_clr_busy;
    logic [AW-1:0]               r_clr_addr;
    logic [AW-1:0]               n_clr_addr;

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* sv/pll_register_file_set_clr_tog.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pll_register_file_set_clr_tog
// Register file with set/clear/toggle aliases and PLL status mirrors.
// ----------------------------------------------------------------------------
// Takes one read or write item per clock while the output is not stalled,
// and returns one result per item via the stage-1 register (memory read),
// then the output register. Set/clear/toggle writes are read-modify-write on
// the single store; a write to the word the next item reads is forwarded, so
// back-to-back items keep the one-per-cycle rate. Lock and DFS-ok status come
// from flip-flop copies of the mirrored bits. After reset the store is cleared
// one word per cycle, and no item is taken until that pass ends.
// ----------------------------------------------------------------------------
module pll_register_file_set_clr_tog #(
    parameter int STORE_WORDS = plrf_pkg::DEF_STORE_WORDS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_kind,
    input  wire logic [plrf_pkg::ADDR_W-1:0] i_word_address,
    input  wire logic [plrf_pkg::DATA_W-1:0] i_write_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [plrf_pkg::DATA_W-1:0]      o_read_data
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [16:0] STORE_LIM = 17'(STORE_WORDS);
    localparam int DW = plrf_pkg::DATA_W;
    localparam int BW = plrf_pkg::BLK_W;

    // stage 0 decode
    plrf_pkg::t_op  s0_op;
    logic [AW-1:0]  s0_addr;
    logic [BW-1:0]  s0_blk;
    logic           s0_lock_upd;
    logic           s0_dfs_upd;
    logic [1:0]     s0_dfs_sel;
    logic [16:0]    s0_wext;
    logic [16:0]    s0_bext;
    logic [7:0]     s0_blk_full;
    logic [5:0]     s0_reg;
    logic [5:0]     s0_base_reg;
    logic [5:0]     s0_dfs_diff;
    logic           s0_in_win;
    logic           s0_in_range;
    logic           in_acc;

    // stage 1
    logic           r_s1_valid;
    logic           n_s1_valid;
    plrf_pkg::t_op  r_s1_op;
    logic [AW-1:0]  r_s1_addr;
    logic [DW-1:0]  r_s1_data;
    logic [BW-1:0]  r_s1_blk;
    logic           r_s1_lock_upd;
    logic           r_s1_dfs_upd;
    logic [1:0]     r_s1_dfs_sel;
    logic           r_s1_fwd;
    logic [DW-1:0]  r_s1_fwd_data;
    logic [DW-1:0]  s1_old;
    logic [DW-1:0]  s1_new;
    logic [DW-1:0]  s1_result;
    logic           s1_we;
    logic           s1_adv;
    logic           fwd_hit;

    logic           r_out_valid;
    logic           n_out_valid;
    logic [DW-1:0]  r_out_data;

    logic                            r_lock [plrf_pkg::PLL_BLOCKS];
    logic [plrf_pkg::DFS_COUNT-1:0]  r_dfs  [plrf_pkg::PLL_BLOCKS];

    logic           st_busy;
    logic [DW-1:0]  st_rd_data;

    plrf_store #(
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (st_busy),
        .i_rd_en   (in_acc),
        .i_rd_addr (s0_addr),
        .o_rd_data (st_rd_data),
        .i_wr_en   (s1_we && s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_new)
    );

    // ---- decode ----
    always_comb begin
        s0_wext     = {3'b000, i_word_address};
        s0_bext     = {3'b000, i_word_address[plrf_pkg::ADDR_W-1:2], 2'b00};
        s0_blk_full = i_word_address[plrf_pkg::ADDR_W-1:6] - plrf_pkg::WIN_FIRST_BLK;
        s0_blk      = s0_blk_full[BW-1:0];
        s0_reg      = i_word_address[5:0];
        s0_base_reg = {i_word_address[5:2], 2'b00};
        s0_dfs_diff = s0_base_reg - plrf_pkg::DFS_FIRST_REG;
        s0_in_win   = (i_word_address >= plrf_pkg::WIN_FIRST_WORD)
                   && (i_word_address < plrf_pkg::WIN_END_WORD);
        s0_in_range = s0_wext < STORE_LIM;
        s0_addr     = s0_wext[AW-1:0];
        s0_lock_upd = 1'b0;
        s0_dfs_upd  = 1'b0;
        s0_dfs_sel  = s0_dfs_diff[4:3];
        s0_op       = plrf_pkg::OP_NOP;
        if (s0_in_win) begin
            if (i_kind == plrf_pkg::KIND_WRITE) begin
                if (s0_reg != plrf_pkg::LOCK_STATUS_REG
                        && s0_reg != plrf_pkg::DFS_STATUS_REG) begin
                    s0_addr     = s0_bext[AW-1:0];
                    s0_lock_upd = s0_base_reg == plrf_pkg::CTRL_REG;
                    s0_dfs_upd  = !s0_dfs_diff[5] && s0_dfs_diff[2:0] == 3'd0;
                    unique case (i_word_address[1:0])
                        plrf_pkg::GRP_ASSIGN: s0_op = plrf_pkg::OP_WRITE;
                        plrf_pkg::GRP_SET:    s0_op = plrf_pkg::OP_SET;
                        plrf_pkg::GRP_CLR:    s0_op = plrf_pkg::OP_CLR;
                        plrf_pkg::GRP_TOG:    s0_op = plrf_pkg::OP_TOG;
                        default:              s0_op = plrf_pkg::OP_NOP;
                    endcase
                end
            end else if (s0_reg == plrf_pkg::LOCK_STATUS_REG) begin
                s0_op = plrf_pkg::OP_READ_LOCK;
            end else if (s0_reg == plrf_pkg::DFS_STATUS_REG) begin
                s0_op = plrf_pkg::OP_READ_DFS;
            end else begin
                s0_op = plrf_pkg::OP_READ_MEM;
            end
        end else if (s0_in_range) begin
            s0_op = (i_kind == plrf_pkg::KIND_WRITE) ? plrf_pkg::OP_WRITE
                                                     : plrf_pkg::OP_READ_MEM;
        end else begin
            s0_op = (i_kind == plrf_pkg::KIND_WRITE) ? plrf_pkg::OP_NOP
                                                     : plrf_pkg::OP_READ_ZERO;
        end
    end

    // ---- stage 1: modify and write back ----
    always_comb begin
        s1_old    = r_s1_fwd ? r_s1_fwd_data : st_rd_data;
        s1_new    = r_s1_data;
        s1_we     = 1'b0;
        s1_result = '0;
        unique case (r_s1_op)
            plrf_pkg::OP_READ_MEM:  s1_result = s1_old;
            plrf_pkg::OP_READ_LOCK: s1_result = DW'(r_lock[r_s1_blk]);
            plrf_pkg::OP_READ_DFS:  s1_result = DW'(r_dfs[r_s1_blk]);
            plrf_pkg::OP_WRITE: begin
                s1_we  = 1'b1;
            end
            plrf_pkg::OP_SET: begin
                s1_we  = 1'b1;
                s1_new = s1_old | r_s1_data;
            end
            plrf_pkg::OP_CLR: begin
                s1_we  = 1'b1;
                s1_new = s1_old & ~r_s1_data;
            end
            plrf_pkg::OP_TOG: begin
                s1_we  = 1'b1;
                s1_new = s1_old ^ r_s1_data;
            end
            default: s1_result = '0;
        endcase
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = st_busy || (r_s1_valid && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fwd_hit    = s1_adv && s1_we && (r_s1_addr == s0_addr);

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < plrf_pkg::PLL_BLOCKS; b++) begin
                r_lock[b] <= 1'b0;
                r_dfs[b]  <= '0;
            end
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_adv && s1_we && r_s1_lock_upd) begin
                r_lock[r_s1_blk] <= s1_new[plrf_pkg::POWERUP_BIT];
            end
            if (s1_adv && s1_we && r_s1_dfs_upd) begin
                r_dfs[r_s1_blk][r_s1_dfs_sel] <= s1_new[plrf_pkg::DFS_ENABLE_BIT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op       <= s0_op;
            r_s1_addr     <= s0_addr;
            r_s1_data     <= i_write_data;
            r_s1_blk      <= s0_blk;
            r_s1_lock_upd <= s0_lock_upd;
            r_s1_dfs_upd  <= s0_dfs_upd;
            r_s1_dfs_sel  <= s0_dfs_sel;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= s1_new;
        end
        if (s1_adv) begin
            r_out_data <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // ---- assertions ----
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !st_busy)
        else $error("item taken during clearing pass");

    a_commit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("committed item not presented");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_we) |=> (o_read_data == '0))
        else $error("write item returned nonzero data");

    a_forward_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fwd_hit) |=> (r_s1_fwd && r_s1_valid))
        else $error("write-back forward lost");

endmodule
`default_nettype wire
